### src/lsbm_pkg.sv
// lsbm_pkg: shared widths, defaults, codes and control types for the lru slot
// buffer manager (controller, datapath and top level)
// no dependencies
package lsbm_pkg;

  // parameter defaults
  localparam int MAX_JOBS_DEF   = 128;
  localparam int STAMP_BITS_DEF = 32;

  // fixed field widths
  localparam int JOB_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 7;
  localparam int LIMIT_W    = 7;
  localparam int JOBCNT_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // register reset values
  localparam logic [LIMIT_W-1:0]  BUFFER_LIMIT_RST = LIMIT_W'(3);
  localparam logic [JOBCNT_W-1:0] JOB_COUNT_RST    = JOBCNT_W'(128);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT    = 1'b1;

  // request types
  localparam logic REQ_ACCESS  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_LOAD     = 3'd1,
    ST_EVICT    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_RANGE    = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request beat
    logic scan_init;   // reset scan address and best candidate
    logic scan_issue;  // read stamp at scan address, advance
    logic commit;      // apply state update, present result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;   // miss with full buffer
    logic scan_last;   // last entry address being issued
  } dp_stat_t;

endpackage

### src/lsbm_ctrl.sv
// lsbm_ctrl: request sequencer for the lru slot buffer manager
// depends on lsbm_pkg (ctrl_cmd_t, dp_stat_t)
module lsbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lsbm_pkg::dp_stat_t   stat_i,
  output lsbm_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = start_i & ~busy_q;
    cmd_o.scan_init  = (state_q == S_DECIDE);
    cmd_o.scan_issue = (state_q == S_SCAN);
    cmd_o.commit     = (state_q == S_COMMIT);
  end

  // state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_DECIDE;
            busy_q  <= 1'b1;
          end
        end
        S_DECIDE: begin
          state_q <= stat_i.need_scan ? S_SCAN : S_COMMIT;
        end
        S_SCAN: begin
          if (stat_i.scan_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last read word is compared this cycle
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;

endmodule

### src/lsbm_dp.sv
// lsbm_dp: datapath of the lru slot buffer manager: config registers, resident
// flags, stamp memory, access counter, eviction scan and result registers
// depends on lsbm_pkg
module lsbm_dp #(
  parameter int MAX_JOBS   = lsbm_pkg::MAX_JOBS_DEF,
  parameter int STAMP_BITS = lsbm_pkg::STAMP_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lsbm_pkg::ctrl_cmd_t                  cmd_i,
  output lsbm_pkg::dp_stat_t                   stat_o,
  input  logic                                 req_type_i,
  input  logic [lsbm_pkg::JOB_W-1:0]           job_index_i,
  input  logic                                 cfg_we_i,
  input  logic [lsbm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lsbm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 done_o,
  output logic [lsbm_pkg::STATUS_W-1:0]        status_o,
  output logic [lsbm_pkg::JOB_W-1:0]           evicted_job_o,
  output logic [lsbm_pkg::COUNT_W-1:0]         resident_count_o
);

  localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int LIM_W0 = $clog2(MAX_JOBS + 1);
  localparam int LIM_W  = (LIM_W0 > lsbm_pkg::JOBCNT_W) ? LIM_W0 : lsbm_pkg::JOBCNT_W;

  // config registers
  logic [lsbm_pkg::LIMIT_W-1:0]  limit_q;
  logic [lsbm_pkg::JOBCNT_W-1:0] job_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= lsbm_pkg::BUFFER_LIMIT_RST;
      job_count_q <= lsbm_pkg::JOB_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsbm_pkg::CFG_BUFFER_LIMIT: limit_q     <= cfg_data_i[lsbm_pkg::LIMIT_W-1:0];
        lsbm_pkg::CFG_JOB_COUNT:    job_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request beat capture
  logic                       req_q;
  logic [lsbm_pkg::JOB_W-1:0] job_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      job_q <= job_index_i;
    end
  end

  // state registers
  logic [MAX_JOBS-1:0]          flags_q, flags_d;
  logic [lsbm_pkg::COUNT_W-1:0] total_q, total_d;
  logic [STAMP_BITS-1:0]        cnt_q, cnt_d, cnt_nxt;
  logic                         done_q;

  // request decode
  logic [LIM_W-1:0] jc_ext, lim;
  logic [IDX_W-1:0] job_idx;
  logic             oor, hit, full;

  assign jc_ext  = LIM_W'(job_count_q);
  assign lim     = (jc_ext > LIM_W'(MAX_JOBS)) ? LIM_W'(MAX_JOBS) : jc_ext;
  assign oor     = (LIM_W'(job_q) >= lim);
  assign job_idx = IDX_W'(job_q);
  assign hit     = flags_q[job_idx];
  assign full    = (total_q >= limit_q) && (total_q != '0);
  assign cnt_nxt = cnt_q + STAMP_BITS'(1);

  assign stat_o.need_scan = ~oor && (req_q == lsbm_pkg::REQ_ACCESS) && ~hit && full;

  // eviction scan: one stamp read per cycle, compared in the cycle after its read
  logic [IDX_W-1:0]      scan_addr_q, rd_idx_q, pos_q;
  logic                  rd_vld_q, found_q;
  logic [STAMP_BITS-1:0] stamp_rd_q, best_q;
  logic                  better;

  assign stat_o.scan_last = (scan_addr_q == IDX_W'(MAX_JOBS - 1));
  assign better = rd_vld_q && flags_q[rd_idx_q] && (!found_q || (stamp_rd_q < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_init) begin
        scan_addr_q <= '0;
        found_q     <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_addr_q <= scan_addr_q + IDX_W'(1);
        end
        if (better) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_idx_q <= scan_addr_q;
    end
    if (better) begin
      pos_q  <= rd_idx_q;
      best_q <= stamp_rd_q;
    end
  end

  // stamp memory; a read entry counts only while its job is resident
  logic [STAMP_BITS-1:0] stamp_mem [MAX_JOBS];
  logic                  stamp_we;

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[job_idx] <= cnt_nxt;
    end
    stamp_rd_q <= stamp_mem[scan_addr_q];
  end

  // commit: next state and result
  lsbm_pkg::status_e            status_d, status_q;
  logic [lsbm_pkg::JOB_W-1:0]   evict_d, evict_q;

  always_comb begin
    flags_d  = flags_q;
    total_d  = total_q;
    cnt_d    = cnt_q;
    status_d = lsbm_pkg::ST_HIT;
    evict_d  = '0;
    stamp_we = 1'b0;
    if (oor) begin
      status_d = lsbm_pkg::ST_RANGE;
    end else if (req_q == lsbm_pkg::REQ_RELEASE) begin
      if (hit) begin
        flags_d[job_idx] = 1'b0;
        if (total_q != '0) begin
          total_d = total_q - lsbm_pkg::COUNT_W'(1);
        end
        status_d = lsbm_pkg::ST_RELEASED;
      end else begin
        status_d = lsbm_pkg::ST_IGNORED;
      end
    end else begin
      stamp_we = cmd_i.commit;
      cnt_d    = cnt_nxt;
      if (hit) begin
        status_d = lsbm_pkg::ST_HIT;
      end else begin
        // victim cleared first, requested job is never the victim
        if (full && found_q) begin
          flags_d[pos_q] = 1'b0;
          status_d       = lsbm_pkg::ST_EVICT;
          evict_d        = lsbm_pkg::JOB_W'(pos_q);
        end else begin
          total_d  = total_q + lsbm_pkg::COUNT_W'(1);
          status_d = lsbm_pkg::ST_LOAD;
        end
        flags_d[job_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      total_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        flags_q <= flags_d;
        total_q <= total_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      evict_q  <= evict_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign evicted_job_o    = evict_q;
  assign resident_count_o = total_q;

endmodule

### src/lru_slot_buffer_manager_core.sv
// lru_slot_buffer_manager_core: top level of the lru slot buffer manager
// depends on lsbm_pkg, lsbm_ctrl, lsbm_dp
//
// Usage:
//   A request beat (req_type_i, job_index_i) is taken at a rising edge with
//   start_i high and busy_o low. busy_o stays high until the request is done.
//   One result beat follows each request: status_o, evicted_job_o and
//   resident_count_o are valid for exactly one cycle while done_o is high.
//   The receiver cannot stall; a new request may be started in the cycle the
//   result is shown.
//   A hit, a release, an out of range index or a miss with room left goes
//   from the decide state straight to commit; a miss that evicts first scans
//   all MAX_JOBS entries, reading one stamp per cycle from the single read port
//   of the stamp memory, and so occupies the block longer than the others.
//   Configuration: cfg_we_i, cfg_idx_i (0 buffer limit, 1 job count) and
//   cfg_data_i write a register at the edge; write only while idle.
//   Reset clears the resident flags, the resident count and the access
//   counter, and loads the register defaults; no clearing pass is needed.
module lru_slot_buffer_manager_core #(
  parameter int MAX_JOBS   = lsbm_pkg::MAX_JOBS_DEF,
  parameter int STAMP_BITS = lsbm_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              req_type_i,
  input  logic [lsbm_pkg::JOB_W-1:0]        job_index_i,
  input  logic                              cfg_we_i,
  input  logic [lsbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lsbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              done_o,
  output logic [lsbm_pkg::STATUS_W-1:0]     status_o,
  output logic [lsbm_pkg::JOB_W-1:0]        evicted_job_o,
  output logic [lsbm_pkg::COUNT_W-1:0]      resident_count_o
);

  lsbm_pkg::ctrl_cmd_t cmd;
  lsbm_pkg::dp_stat_t  stat;

  // sequencer
  lsbm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath
  lsbm_dp #(
    .MAX_JOBS   (MAX_JOBS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_type_i),
    .job_index_i      (job_index_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .evicted_job_o    (evicted_job_o),
    .resident_count_o (resident_count_o)
  );

endmodule

### tb/sv/slot_buffer_checker.sv
// slot_buffer_checker: watches request, config and result beats of the lru slot
// buffer manager, predicts each result and compares it with the block's output
// depends on lsbm_pkg
`timescale 1ns / 100ps

module slot_buffer_checker #(
  parameter int MAX_JOBS   = lsbm_pkg::MAX_JOBS_DEF,
  parameter int STAMP_BITS = lsbm_pkg::STAMP_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            req_type_i,
  input  logic [lsbm_pkg::JOB_W-1:0]      job_index_i,
  input  logic                            cfg_we_i,
  input  logic [lsbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            done_i,
  input  logic [lsbm_pkg::STATUS_W-1:0]   status_i,
  input  logic [lsbm_pkg::JOB_W-1:0]      evicted_job_i,
  input  logic [lsbm_pkg::COUNT_W-1:0]    resident_count_i,
  output int                              errors_o,
  output int                              pending_o
);

  typedef struct packed {
    lsbm_pkg::status_e                status;
    logic [lsbm_pkg::JOB_W-1:0]       evicted;
    logic [lsbm_pkg::COUNT_W-1:0]     residents;
  } slot_outcome_t;

  // shadow state of the buffer manager
  logic [MAX_JOBS-1:0]              is_resident;
  logic [STAMP_BITS-1:0]            last_use [MAX_JOBS];
  logic [STAMP_BITS-1:0]            use_clock;
  logic [lsbm_pkg::COUNT_W-1:0]     resident_cnt;
  logic [lsbm_pkg::LIMIT_W-1:0]     limit_reg;
  logic [lsbm_pkg::JOBCNT_W-1:0]    jobs_reg;

  slot_outcome_t outcome_q[$];
  slot_outcome_t want;
  slot_outcome_t got;
  int            fails = 0;

  assign errors_o = fails;

  // apply one request to the shadow state and return its outcome
  function automatic slot_outcome_t serve_request(input logic kind,
                                                  input logic [lsbm_pkg::JOB_W-1:0] job);
    slot_outcome_t              o;
    int                         span;
    logic                       found;
    logic [lsbm_pkg::JOB_W-1:0] victim;
    logic [STAMP_BITS-1:0]      oldest;
    o.status  = lsbm_pkg::ST_HIT;
    o.evicted = '0;
    span = (int'(jobs_reg) > MAX_JOBS) ? MAX_JOBS : int'(jobs_reg);
    if (int'(job) >= span) begin
      o.status = lsbm_pkg::ST_RANGE;
    end else if (kind == lsbm_pkg::REQ_RELEASE) begin
      if (is_resident[job]) begin
        is_resident[job] = 1'b0;
        if (resident_cnt != '0) resident_cnt = resident_cnt - lsbm_pkg::COUNT_W'(1);
        o.status = lsbm_pkg::ST_RELEASED;
      end else begin
        o.status = lsbm_pkg::ST_IGNORED;
      end
    end else begin
      if (!is_resident[job]) begin
        o.status = lsbm_pkg::ST_LOAD;
        // full buffer: drop the least recently used job, lowest index on a tie
        if (resident_cnt >= lsbm_pkg::COUNT_W'(limit_reg) && resident_cnt != '0) begin
          found  = 1'b0;
          victim = '0;
          oldest = '0;
          for (int i = 0; i < MAX_JOBS; i++) begin
            if (is_resident[i] && (!found || last_use[i] < oldest)) begin
              found  = 1'b1;
              victim = lsbm_pkg::JOB_W'(i);
              oldest = last_use[i];
            end
          end
          if (found) begin
            is_resident[victim] = 1'b0;
            resident_cnt        = resident_cnt - lsbm_pkg::COUNT_W'(1);
            o.evicted           = victim;
            o.status            = lsbm_pkg::ST_EVICT;
          end
        end
        is_resident[job] = 1'b1;
        resident_cnt     = resident_cnt + lsbm_pkg::COUNT_W'(1);
      end
      use_clock     = use_clock + STAMP_BITS'(1);
      last_use[job] = use_clock;
    end
    o.residents = resident_cnt;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_resident  = '0;
      for (int i = 0; i < MAX_JOBS; i++) last_use[i] = '0;
      use_clock    = '0;
      resident_cnt = '0;
      limit_reg    = lsbm_pkg::BUFFER_LIMIT_RST;
      jobs_reg     = lsbm_pkg::JOB_COUNT_RST;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      // result beat against the oldest expectation
      if (done_i) begin
        got.status    = lsbm_pkg::status_e'(status_i);
        got.evicted   = evicted_job_i;
        got.residents = resident_count_i;
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d evicted %0d count %0d",
                   $time, got.status, got.evicted, got.residents);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            $display({"%0t: result mismatch, expected status %0d evicted %0d count %0d,",
                      " actual status %0d evicted %0d count %0d"},
                     $time, want.status, want.evicted, want.residents,
                     got.status, got.evicted, got.residents);
            fails++;
          end
        end
      end
      // register write
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lsbm_pkg::CFG_BUFFER_LIMIT: limit_reg = cfg_data_i[lsbm_pkg::LIMIT_W-1:0];
          lsbm_pkg::CFG_JOB_COUNT:    jobs_reg  = cfg_data_i[lsbm_pkg::JOBCNT_W-1:0];
          default: ;
        endcase
      end
      // request beat
      if (start_i && !busy_i) outcome_q.push_back(serve_request(req_type_i, job_index_i));
      pending_o <= outcome_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// testbench: drives directed and random request beats and register settings
// into lru_slot_buffer_manager_core; checking is done by slot_buffer_checker
// depends on lsbm_pkg, lru_slot_buffer_manager_core, slot_buffer_checker
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_JOBS    = lsbm_pkg::MAX_JOBS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASES      = 10;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            start     = 1'b0;
  logic                            req_type  = lsbm_pkg::REQ_ACCESS;
  logic [lsbm_pkg::JOB_W-1:0]      job_index = '0;
  logic                            cfg_we    = 1'b0;
  logic [lsbm_pkg::CFG_IDX_W-1:0]  cfg_idx   = lsbm_pkg::CFG_BUFFER_LIMIT;
  logic [lsbm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            busy;
  logic                            done;
  logic [lsbm_pkg::STATUS_W-1:0]   status;
  logic [lsbm_pkg::JOB_W-1:0]      evicted_job;
  logic [lsbm_pkg::COUNT_W-1:0]    resident_count;
  int                              errors;
  int                              pending;
  int                              cycles = 0;

  // per phase settings: buffer limit, job count and number of beats
  int limit_tab [PHASES] = '{3, 2, 100, 4, 0, 1, 127, 5, 6, 2};
  int jobs_tab  [PHASES] = '{128, 128, 128, 16, 8, 2, 255, 0, 1, 128};
  int beats_tab [PHASES] = '{300, 200, 250, 200, 150, 100, 250, 30, 60, 400};

  always #6 clk = ~clk;

  lru_slot_buffer_manager_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .req_type_i       (req_type),
    .job_index_i      (job_index),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .done_o           (done),
    .status_o         (status),
    .evicted_job_o    (evicted_job),
    .resident_count_o (resident_count)
  );

  slot_buffer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type),
    .job_index_i      (job_index),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .done_i           (done),
    .status_i         (status),
    .evicted_job_i    (evicted_job),
    .resident_count_i (resident_count),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // present one request beat and wait until it is taken and busy has dropped
  task automatic send_req(input logic kind, input logic [lsbm_pkg::JOB_W-1:0] job);
    start     <= 1'b1;
    req_type  <= kind;
    job_index <= job;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_reg(input logic [lsbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsbm_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // random beat: mostly accesses in a working set a bit larger than the limit
  task automatic random_beat(input int lim, input int span);
    int                         r;
    int                         w;
    logic                       kind;
    logic [lsbm_pkg::JOB_W-1:0] job;
    r = $urandom_range(0, 99);
    w = (lim < 1 ? 1 : lim) + int'($urandom_range(1, 3));
    if (w > span) w = span;
    if (span == 0 || r < 5) begin
      kind = 1'($urandom_range(0, 1));
      job  = lsbm_pkg::JOB_W'($urandom_range(0, 127));
    end else if (r < 12 && span < 128) begin
      kind = 1'($urandom_range(0, 1));
      job  = lsbm_pkg::JOB_W'($urandom_range(span, 127));
    end else if (r < 25) begin
      kind = lsbm_pkg::REQ_RELEASE;
      job  = lsbm_pkg::JOB_W'($urandom_range(0, w - 1));
    end else begin
      kind = lsbm_pkg::REQ_ACCESS;
      job  = lsbm_pkg::JOB_W'($urandom_range(0, w - 1));
    end
    send_req(kind, job);
  endtask

  initial begin
    int span;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill, hit, evict, release and double release at reset settings
    send_req(lsbm_pkg::REQ_ACCESS, 7'd0);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd127);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd64);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd0);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd1);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd64);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd64);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd127);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd2);
    // lowered job count: out of range both ways, eviction of a job above the count
    write_reg(lsbm_pkg::CFG_JOB_COUNT, 8'd8);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd10);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd100);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd7);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd3);
    // limit of zero and one keep a single job resident once the buffer is emptied
    write_reg(lsbm_pkg::CFG_BUFFER_LIMIT, 8'd0);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd4);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd3);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd7);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd4);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd5);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd6);
    write_reg(lsbm_pkg::CFG_BUFFER_LIMIT, 8'd1);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd0);
    // no valid index at all
    write_reg(lsbm_pkg::CFG_JOB_COUNT, 8'd0);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd0);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd0);
    // job count above maximum acts as maximum, upper data bit on the limit
    write_reg(lsbm_pkg::CFG_JOB_COUNT, 8'd255);
    write_reg(lsbm_pkg::CFG_BUFFER_LIMIT, 8'h82);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd127);
    send_req(lsbm_pkg::REQ_ACCESS, 7'd85);
    send_req(lsbm_pkg::REQ_RELEASE, 7'd127);

    // random phases over a range of settings, the last one without gaps
    for (int p = 0; p < PHASES; p++) begin
      write_reg(lsbm_pkg::CFG_BUFFER_LIMIT, lsbm_pkg::CFG_DATA_W'(limit_tab[p]));
      write_reg(lsbm_pkg::CFG_JOB_COUNT, lsbm_pkg::CFG_DATA_W'(jobs_tab[p]));
      span = (jobs_tab[p] > MAX_JOBS) ? MAX_JOBS : jobs_tab[p];
      for (int k = 0; k < beats_tab[p]; k++) begin
        random_beat(limit_tab[p], span);
        if (p != PHASES - 1) begin
          if ($urandom_range(0, 5) == 0) idle($urandom_range(1, 19));
          else if ($urandom_range(0, 59) == 0) drain();
        end
      end
    end

    drain();
    repeat (MAX_JOBS + 10) @(posedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
